// ----- hw/rtl/lpft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpft_pkg
// shared types and codes for the lru page frame table
// ----------------------------------------------------------------------------
package lpft_pkg;

    localparam int FRAMES_DEF = 16;
    localparam int PAGE_W     = 31;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 4;
    localparam int FRAME_W    = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_FETCH = 2'd0,
        MODE_PIN   = 2'd1,
        MODE_UNPIN = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PINNED_HIT  = 4'd0,
        ST_HIT         = 4'd1,
        ST_LOAD_FREE   = 4'd2,
        ST_LOAD_EVICT  = 4'd3,
        ST_NO_FRAME    = 4'd4,
        ST_PINNED      = 4'd5,
        ST_ALREADY_PIN = 4'd6,
        ST_NOT_RES     = 4'd7,
        ST_UNPINNED    = 4'd8,
        ST_NOT_PINNED  = 4'd9
    } status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;     // capture request
        logic lookup;   // register search results
        logic commit;   // apply update for decided action
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic    drop;  // unused mode, no result
    } stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lru_page_frame_table_with_pins_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_page_frame_table_with_pins_top
// lru page frame table with pinning
// ----------------------------------------------------------------------------
// Each request word passes through load, associative lookup and victim
// search, rank update and output; the next request can be taken only after
// its result word has been accepted on out_ready, so one request is in flight
// at a time. A word with the unused mode gives no result and frees the block
// without an output step.
module lru_page_frame_table_with_pins_top
    import lpft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [PAGE_W-1:0]   page_id,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [FRAME_W-1:0]       frame,
    output logic                     needs_load,
    output logic                     evicted_valid,
    output logic [PAGE_W-1:0]        evicted_page_id
);

    cmd_t  cmd;
    stat_t stat;

    lpft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    lpft_datapath #(.FRAMES(FRAMES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .mode         (mode),
        .page_id      (page_id),
        .res_status   (status),
        .res_frame    (frame),
        .res_load     (needs_load),
        .res_ev_valid (evicted_valid),
        .res_ev_page  (evicted_page_id)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/lpft_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpft_datapath
// frame table, associative lookup, victim search and rank update
// ----------------------------------------------------------------------------
module lpft_datapath
    import lpft_pkg::*;
#(
    parameter int FRAMES = FRAMES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cmd_t                cmd,
    output stat_t                    stat,
    input  wire logic [MODE_W-1:0]   mode,
    input  wire logic [PAGE_W-1:0]   page_id,
    output logic [STATUS_W-1:0]      res_status,
    output logic [FRAME_W-1:0]       res_frame,
    output logic                     res_load,
    output logic                     res_ev_valid,
    output logic [PAGE_W-1:0]        res_ev_page
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [PAGE_W-1:0] page_reg [FRAMES];
    logic [FRAMES-1:0] used_reg, locked_reg;
    logic [IDX_W-1:0]  rank_reg [FRAMES];
    logic [CNT_W-1:0]  fresh_reg;

    logic [MODE_W-1:0] mode_reg;
    logic [PAGE_W-1:0] req_reg;

    // lookup results
    logic              hit_reg, vic_ok_reg;
    logic [IDX_W-1:0]  hit_idx_reg, vic_idx_reg;

    logic              hit_c, vic_ok_c;
    logic [IDX_W-1:0]  hit_idx_c, vic_idx_c;
    logic [CNT_W-1:0]  live_c;

    always_comb
    begin
        live_c    = CNT_W'($countones(used_reg & ~locked_reg));
        hit_c     = 1'b0;
        hit_idx_c = '0;
        vic_ok_c  = (live_c != '0);
        vic_idx_c = '0;
        for (int i = 0; i < FRAMES; i++)
        begin
            if (used_reg[i] && page_reg[i] == req_reg)
            begin
                hit_c     = 1'b1;
                hit_idx_c = hit_idx_c | IDX_W'(i);
            end
            // least recent unpinned frame holds the top rank
            if (used_reg[i] && !locked_reg[i]
                && CNT_W'(rank_reg[i]) == live_c - CNT_W'(1))
                vic_idx_c = vic_idx_c | IDX_W'(i);
        end
    end

    // decide action from registered lookup
    logic              fresh_ok;
    logic [IDX_W-1:0]  tgt;
    logic              do_remove, do_push, do_lock, do_unlock, do_fill, do_fresh;
    logic [STATUS_W-1:0] st_c;
    logic              fr_ok;

    assign fresh_ok = fresh_reg < CNT_W'(FRAMES);

    always_comb
    begin
        tgt = hit_idx_reg;
        do_remove = 1'b0; do_push = 1'b0; do_lock = 1'b0; do_unlock = 1'b0;
        do_fill = 1'b0; do_fresh = 1'b0;
        st_c  = ST_NOT_PINNED;
        fr_ok = hit_reg;
        unique case (mode_reg)
            MODE_FETCH:
            begin
                if (hit_reg)
                begin
                    if (locked_reg[hit_idx_reg])
                        st_c = ST_PINNED_HIT;
                    else
                    begin
                        st_c = ST_HIT; do_remove = 1'b1; do_push = 1'b1;
                    end
                end
                else if (fresh_ok)
                begin
                    st_c = ST_LOAD_FREE; tgt = fresh_reg[IDX_W-1:0];
                    do_fresh = 1'b1; do_fill = 1'b1; do_push = 1'b1; fr_ok = 1'b1;
                end
                else if (vic_ok_reg)
                begin
                    st_c = ST_LOAD_EVICT; tgt = vic_idx_reg; fr_ok = 1'b1;
                    do_remove = 1'b1; do_fill = 1'b1; do_push = 1'b1;
                end
                else
                    st_c = ST_NO_FRAME;
            end
            MODE_PIN:
            begin
                if (!hit_reg)
                    st_c = ST_NOT_RES;
                else if (locked_reg[hit_idx_reg])
                    st_c = ST_ALREADY_PIN;
                else
                begin
                    st_c = ST_PINNED; do_remove = 1'b1; do_lock = 1'b1;
                end
            end
            MODE_UNPIN:
            begin
                if (hit_reg && locked_reg[hit_idx_reg])
                begin
                    st_c = ST_UNPINNED; do_unlock = 1'b1; do_push = 1'b1;
                end
            end
            default: st_c = ST_NOT_PINNED;
        endcase
    end

    assign stat.drop = (mode_reg == MODE_NONE);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            req_reg  <= page_id;
        end
        if (cmd.lookup)
        begin
            hit_reg     <= hit_c;
            hit_idx_reg <= hit_idx_c;
            vic_ok_reg  <= vic_ok_c;
            vic_idx_reg <= vic_idx_c;
        end
        if (cmd.commit)
        begin
            res_status   <= st_c;
            res_frame    <= fr_ok ? FRAME_W'(tgt) : '0;
            res_load     <= do_fill;
            res_ev_valid <= do_fill && !do_fresh;
            res_ev_page  <= (do_fill && !do_fresh) ? page_reg[tgt] : '0;
            if (do_fill)
                page_reg[tgt] <= req_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            locked_reg <= '0;
            fresh_reg  <= '0;
            for (int i = 0; i < FRAMES; i++)
                rank_reg[i] <= '0;
        end
        else if (cmd.commit)
        begin
            if (do_fresh)
            begin
                fresh_reg     <= fresh_reg + CNT_W'(1);
                used_reg[tgt] <= 1'b1;
            end
            if (do_lock)
                locked_reg[tgt] <= 1'b1;
            if (do_unlock)
                locked_reg[tgt] <= 1'b0;
            for (int i = 0; i < FRAMES; i++)
            begin
                if (IDX_W'(i) == tgt)
                begin
                    if (do_remove || do_push)
                        rank_reg[i] <= '0;
                end
                else if (used_reg[i] && !locked_reg[i])
                begin
                    if (do_remove && do_push)
                    begin
                        if (rank_reg[i] < rank_reg[tgt])
                            rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                    else if (do_remove)
                    begin
                        if (rank_reg[i] > rank_reg[tgt])
                            rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                    end
                    else if (do_push)
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                end
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit && do_fresh |=> used_reg != '0)
    else $error("fresh fill left no used frame");
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(locked_reg & ~used_reg) == 0)
    else $error("pinned frame not in use");
    assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CNT_W'(FRAMES))
    else $error("fresh count overflow");

endmodule
`default_nettype wire

// ----- hw/rtl/lpft_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpft_ctrl
// request sequencer and output handshake
// ----------------------------------------------------------------------------
module lpft_ctrl
    import lpft_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output cmd_t       cmd,
    input  wire stat_t stat
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOKUP = 4'b0010,
        S_COMMIT = 4'b0100,
        S_OUT    = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign cmd.load   = in_ready && in_valid;
    assign cmd.lookup = (state_reg == S_LOOKUP);
    assign cmd.commit = (state_reg == S_COMMIT) && !stat.drop;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_valid) state_next = S_LOOKUP;
            S_LOOKUP: state_next = S_COMMIT;
            S_COMMIT: state_next = stat.drop ? S_IDLE : S_OUT;
            S_OUT:    if (out_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
    else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n) cmd.commit |=> out_valid)
    else $error("commit without result");
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input taken while result pending");

endmodule
`default_nettype wire

// ----- test/tb_lru_page_frame_table_with_pins_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_frame_table_with_pins_top
// drives fetch, pin, unpin and unused-mode words with random gaps and output stalls,
// predicts each result from a behavioral frame table and checks it in order
// ----------------------------------------------------------------------------
module tb_lru_page_frame_table_with_pins_top
    import lpft_pkg::*;
();

    localparam int NF = FRAMES_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic                needs_load;
        logic                evicted_valid;
        logic [PAGE_W-1:0]   evicted_page_id;
    } frame_reply_t;

    class frame_table_scoreboard;
        logic [PAGE_W-1:0] page_of[NF];
        bit                used[NF];
        bit                locked[NF];
        int                rank[NF];
        int                fresh;
        frame_reply_t      pending[$];
        int                errors;

        function new();
            foreach (used[i])
            begin
                used[i] = 0;
                locked[i] = 0;
                rank[i] = 0;
                page_of[i] = '0;
            end
            fresh = 0;
            errors = 0;
        endfunction

        function bit ordered(int i);
            return used[i] && !locked[i];
        endfunction

        function void unlink(int f);
            foreach (rank[i])
                if (i != f && ordered(i) && rank[i] > rank[f])
                    rank[i]--;
            rank[f] = 0;
        endfunction

        function void make_recent(int f);
            foreach (rank[i])
                if (i != f && ordered(i))
                    rank[i]++;
            rank[f] = 0;
        endfunction

        function void note_request(logic [MODE_W-1:0] m, logic [PAGE_W-1:0] p);
            frame_reply_t r;
            int           f;
            int           v;
            f = -1;
            v = -1;
            r = '0;
            foreach (used[i])
                if (f < 0 && used[i] && page_of[i] == p)
                    f = i;
            if (m == MODE_NONE)
                return;
            if (m == MODE_FETCH)
            begin
                if (f >= 0 && locked[f])
                begin
                    r.status = ST_PINNED_HIT;
                    r.frame = FRAME_W'(f);
                end
                else if (f >= 0)
                begin
                    unlink(f);
                    make_recent(f);
                    r.status = ST_HIT;
                    r.frame = FRAME_W'(f);
                end
                else if (fresh < NF)
                begin
                    f = fresh;
                    fresh++;
                    used[f] = 1;
                    locked[f] = 0;
                    page_of[f] = p;
                    make_recent(f);
                    r.status = ST_LOAD_FREE;
                    r.frame = FRAME_W'(f);
                    r.needs_load = 1;
                end
                else
                begin
                    foreach (used[i])
                        if (ordered(i) && (v < 0 || rank[i] > rank[v]))
                            v = i;
                    if (v < 0)
                        r.status = ST_NO_FRAME;
                    else
                    begin
                        r.status = ST_LOAD_EVICT;
                        r.frame = FRAME_W'(v);
                        r.needs_load = 1;
                        r.evicted_valid = 1;
                        r.evicted_page_id = page_of[v];
                        unlink(v);
                        page_of[v] = p;
                        make_recent(v);
                    end
                end
            end
            else if (m == MODE_PIN)
            begin
                if (f < 0)
                    r.status = ST_NOT_RES;
                else if (locked[f])
                begin
                    r.status = ST_ALREADY_PIN;
                    r.frame = FRAME_W'(f);
                end
                else
                begin
                    unlink(f);
                    locked[f] = 1;
                    r.status = ST_PINNED;
                    r.frame = FRAME_W'(f);
                end
            end
            else
            begin
                if (f < 0 || !locked[f])
                begin
                    r.status = ST_NOT_PINNED;
                    r.frame = (f < 0) ? '0 : FRAME_W'(f);
                end
                else
                begin
                    locked[f] = 0;
                    make_recent(f);
                    r.status = ST_UNPINNED;
                    r.frame = FRAME_W'(f);
                end
            end
            pending.insert(pending.size(), r);
        endfunction

        function void check_reply(frame_reply_t got);
            frame_reply_t want;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected word: actual %h", $time, got);
                errors++;
                return;
            end
            want = pending[0];
            pending.delete(0);
            if (got.status !== want.status)
                $display("%0t status: expected %0d actual %0d", $time, want.status, got.status);
            if (got.frame !== want.frame)
                $display("%0t frame: expected %0d actual %0d", $time, want.frame, got.frame);
            if (got.needs_load !== want.needs_load)
                $display("%0t needs_load: expected %0d actual %0d", $time, want.needs_load,
                         got.needs_load);
            if (got.evicted_valid !== want.evicted_valid)
                $display("%0t evicted_valid: expected %0d actual %0d", $time,
                         want.evicted_valid, got.evicted_valid);
            if (got.evicted_page_id !== want.evicted_page_id)
                $display("%0t evicted_page_id: expected %h actual %h", $time,
                         want.evicted_page_id, got.evicted_page_id);
            if (got !== want)
                errors++;
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [MODE_W-1:0]   mode;
    logic [PAGE_W-1:0]   page_id;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [FRAME_W-1:0]  frame;
    logic                needs_load;
    logic                evicted_valid;
    logic [PAGE_W-1:0]   evicted_page_id;

    frame_table_scoreboard sb;
    int                    cycle_count;
    bit                    hold_off;
    bit                    gaps_on;
    logic [PAGE_W-1:0]     hot_pages[24];

    lru_page_frame_table_with_pins_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .page_id        (page_id),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .frame          (frame),
        .needs_load     (needs_load),
        .evicted_valid  (evicted_valid),
        .evicted_page_id(evicted_page_id)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("tb_lru_page_frame_table_with_pins_top: errors");
            $finish;
        end
        if (rst_n && in_valid && in_ready)
            sb.note_request(mode, page_id);
        if (rst_n && out_valid && out_ready)
            sb.check_reply({status, frame, needs_load, evicted_valid, evicted_page_id});
    end

    // receiver stall pattern
    always @(negedge clk)
    begin
        if (hold_off)
            out_ready <= 1'b0;
        else if (!gaps_on)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_word(input logic [MODE_W-1:0] m, input logic [PAGE_W-1:0] p);
        in_valid <= 1'b1;
        mode <= m;
        page_id <= p;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic idle(input int n);
        in_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_burst(input int count);
        int                n;
        int                pick;
        logic [MODE_W-1:0] m;
        logic [PAGE_W-1:0] p;
        for (int k = 0; k < count; k++)
        begin
            n = $urandom_range(1, 12);
            for (int j = 0; j < n; j++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    m = MODE_FETCH;
                else if (pick < 75)
                    m = MODE_PIN;
                else if (pick < 97)
                    m = MODE_UNPIN;
                else
                    m = MODE_NONE;
                if ($urandom_range(0, 9) == 0)
                    p = PAGE_W'($urandom);
                else
                    p = hot_pages[$urandom_range(0, 23)];
                send_word(m, p);
            end
            if (gaps_on)
                idle($urandom_range(0, 6));
        end
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        hold_off = 0;
        gaps_on = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_FETCH;
        page_id = '0;
        out_ready = 1'b0;
        for (int i = 0; i < 24; i++)
            hot_pages[i] = (i < 2) ? (i ? {PAGE_W{1'b1}} : '0) : PAGE_W'($urandom);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        send_word(MODE_PIN, hot_pages[0]);
        send_word(MODE_UNPIN, hot_pages[1]);
        send_word(MODE_NONE, hot_pages[0]);
        for (int i = 0; i < 16; i++)
            send_word(MODE_FETCH, hot_pages[i]);
        send_word(MODE_FETCH, hot_pages[1]);
        send_word(MODE_PIN, hot_pages[1]);
        send_word(MODE_PIN, hot_pages[1]);
        send_word(MODE_FETCH, hot_pages[1]);
        send_word(MODE_UNPIN, hot_pages[2]);
        send_word(MODE_FETCH, hot_pages[16]);
        send_word(MODE_UNPIN, hot_pages[1]);
        drain();

        // all frames pinned
        for (int i = 0; i < 16; i++)
            send_word(MODE_PIN, sb.page_of[i]);
        send_word(MODE_FETCH, hot_pages[20]);
        for (int i = 0; i < 16; i++)
            send_word(MODE_UNPIN, sb.page_of[i]);

        // receiver holds off while words keep coming
        hold_off = 1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_off = 0;
            end
            random_burst(4);
        join
        drain();

        gaps_on = 1;
        random_burst(80);
        drain();
        gaps_on = 0;
        random_burst(40);
        gaps_on = 1;
        random_burst(40);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_lru_page_frame_table_with_pins_top: clean");
        else
            $display("tb_lru_page_frame_table_with_pins_top: errors");
        $finish;
    end
endmodule
